### hw/rtl/npc_pkg.sv
// Shared types, constants and the reset palette for the nearest palette color unit.
// No dependencies; used by npc_cell and nearest_palette_color_unit.
`default_nettype none

package npc_pkg;

   // Default palette size and the size of the built-in reset table
   localparam int unsigned PALETTE_ENTRIES_DEF = 16;
   localparam int unsigned RESET_TABLE_SIZE    = 16;

   // Largest possible squared RGB distance (3 * 255 * 255)
   localparam logic [17:0] MAX_DISTANCE = 18'd195075;

   // Item kind carried on req_tuser
   typedef enum logic {
      REQ_QUERY = 1'b0,
      REQ_WRITE = 1'b1
   } req_kind_type;

   // Item traveling down the cell row: the request plus the running best match
   typedef struct packed {
      logic         valid;
      req_kind_type kind;
      logic [3:0]   entry_index;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
      logic [3:0]   best_index;
      logic [17:0]  best_distance;
   } token_type;

   // Reset color of one palette entry as {red, green, blue}; entries past the table are black
   function automatic logic [23:0] reset_color(input int unsigned idx);
      logic [23:0] rgb;
      case (idx)
         0:       rgb = 24'h000000;
         1:       rgb = 24'hFFFFFF;
         2:       rgb = 24'h883932;
         3:       rgb = 24'h67B6BD;
         4:       rgb = 24'h8B3F96;
         5:       rgb = 24'h55A049;
         6:       rgb = 24'h40318D;
         7:       rgb = 24'hBFCE72;
         8:       rgb = 24'h8B5429;
         9:       rgb = 24'h574200;
         10:      rgb = 24'hB86962;
         11:      rgb = 24'h505050;
         12:      rgb = 24'h787878;
         13:      rgb = 24'h94E089;
         14:      rgb = 24'h7869C4;
         15:      rgb = 24'h9F9F9F;
         default: rgb = 24'h000000;
      endcase
      return rgb;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/npc_cell.sv
// One cell of the palette row: holds one palette entry, applies writes addressed to it
// and folds its distance into a passing query. Depends on npc_pkg.
`default_nettype none

module npc_cell #(
   parameter int unsigned INDEX = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire npc_pkg::token_type tok_i,
   output npc_pkg::token_type      tok_o
);

   localparam logic [23:0] RESET_RGB = npc_pkg::reset_color(INDEX);
   localparam bit          FIRST     = (INDEX == 0);
   localparam bit          ADDRESSED = (INDEX < 16);
   localparam logic [3:0]  CELL_ID   = 4'(INDEX);

   logic [23:0]        color_ff;
   logic [23:0]        color_in;
   npc_pkg::token_type tok_ff;
   npc_pkg::token_type tok_in;

   logic [7:0]  diff_r, diff_g, diff_b;
   logic [15:0] sq_r, sq_g, sq_b;
   logic [17:0] cand_distance;
   logic        write_hit;
   logic        take;

   // Absolute channel differences against the stored entry
   always_comb begin
      diff_r = (color_ff[23:16] >= tok_i.red)   ? color_ff[23:16] - tok_i.red
                                                : tok_i.red - color_ff[23:16];
      diff_g = (color_ff[15:8] >= tok_i.green)  ? color_ff[15:8] - tok_i.green
                                                : tok_i.green - color_ff[15:8];
      diff_b = (color_ff[7:0] >= tok_i.blue)    ? color_ff[7:0] - tok_i.blue
                                                : tok_i.blue - color_ff[7:0];
   end

   // Squared distance and strict-less compare, so the lower index keeps a tie
   always_comb begin
      sq_r = diff_r * diff_r;
      sq_g = diff_g * diff_g;
      sq_b = diff_b * diff_b;
      cand_distance = 18'(sq_r) + 18'(sq_g) + 18'(sq_b);
      take = FIRST || (cand_distance < tok_i.best_distance);
   end

   // Update the entry on a write addressed to this cell
   always_comb begin
      write_hit = ADDRESSED && tok_i.valid && (tok_i.kind == npc_pkg::REQ_WRITE)
                  && (tok_i.entry_index == CELL_ID);
      color_in = color_ff;
      if (advance && write_hit) begin
         color_in = {tok_i.red, tok_i.green, tok_i.blue};
      end
   end

   // Pass the item on, replacing the best match when this entry is closer
   always_comb begin
      tok_in = tok_i;
      if (tok_i.kind == npc_pkg::REQ_QUERY && take) begin
         tok_in.best_index    = CELL_ID;
         tok_in.best_distance = cand_distance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= RESET_RGB;
      end else begin
         color_ff <= color_in;
      end
   end

   // Advance the item register; only its valid bit is cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

`default_nettype wire

### hw/rtl/nearest_palette_color_unit.sv
// Nearest palette color unit: input handshake, the row of palette cells and the result register.
// Depends on npc_pkg and npc_cell.
//
// Usage:
//   Input channel req_*: req_tuser selects a query (0) or a palette write (1);
//   req_tdata carries entry_index, red, green and blue. A query returns one
//   transfer on rsp_* with the index of the closest palette entry (lowest
//   index on a tie) and its squared RGB distance. A write replaces one entry
//   and returns nothing; a write to an index at or past PALETTE_ENTRIES is dropped.
//   Each palette entry lives in its own cell; while the row advances, an item moves
//   one cell per cycle, so writes and queries take effect strictly in arrival order.
//   Throughput: one item per cycle while the row is not stalled. An input transfer
//   reaches rsp_tvalid after passing the register of each cell in the row and then
//   the result register.
//   Stall: when a result waits in the output register and rsp_tready is low,
//   the whole row holds and req_tready drops in the same cycle.
//   Reset: synchronous, active high; clears all items in flight and reloads the
//   sixteen-color reset palette (entries past sixteen reset to black).
`default_nettype none

module nearest_palette_color_unit #(
   parameter int unsigned PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // entry_index[3:0], red[11:4], green[19:12], blue[27:20]
   input  wire logic [0:0]  req_tuser,  // req_type[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata   // nearest_index[3:0], nearest_distance[21:4]
);

   npc_pkg::token_type tok [0:PALETTE_ENTRIES];

   logic        advance;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [3:0]  rsp_index_ff;
   logic [17:0] rsp_distance_ff;

   // Move the row whenever the result register is free or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Build the head item from the input transfer
   always_comb begin
      tok[0].valid         = req_tvalid && advance;
      tok[0].kind          = npc_pkg::req_kind_type'(req_tuser[0]);
      tok[0].entry_index   = req_tdata[3:0];
      tok[0].red           = req_tdata[11:4];
      tok[0].green         = req_tdata[19:12];
      tok[0].blue          = req_tdata[27:20];
      tok[0].best_index    = 4'd0;
      tok[0].best_distance = 18'd0;
   end

   // One cell per palette entry
   for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
      npc_cell #(
         .INDEX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_i   (tok[i]),
         .tok_o   (tok[i+1])
      );
   end

   // Capture finished queries; drop writes at the end of the row
   assign rsp_valid_in = tok[PALETTE_ENTRIES].valid
                         && (tok[PALETTE_ENTRIES].kind == npc_pkg::REQ_QUERY);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_index_ff    <= tok[PALETTE_ENTRIES].best_index;
         rsp_distance_ff <= tok[PALETTE_ENTRIES].best_distance;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_distance_ff, rsp_index_ff};

   // A presented distance never exceeds the largest squared RGB distance
   a_distance_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_distance_ff <= npc_pkg::MAX_DISTANCE))
      else $error("nearest distance out of range");

   // The row holds still while the result register is stalled
   a_row_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(tok[PALETTE_ENTRIES]))
      else $error("cell row moved during a stall");

   // A write leaving the row never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (advance && tok[PALETTE_ENTRIES].valid
       && tok[PALETTE_ENTRIES].kind == npc_pkg::REQ_WRITE) |=> !rsp_valid_ff)
      else $error("palette write produced a result");

   // A stall only happens with a result waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a waiting result");

endmodule

`default_nettype wire
